// ===== sv/oct_pkg.sv =====
// shared widths, cell word type for the octahedral normal encoder
`default_nettype none
package oct_pkg;

  localparam int COMPONENT_WIDTH = 16;
  localparam int Q_W   = 15;
  localparam int OUT_W = Q_W + 1;
  localparam int MAG_W = COMPONENT_WIDTH + 1;
  localparam int SUM_W = COMPONENT_WIDTH + 2;
  localparam int NUM_W = MAG_W + Q_W;
  localparam int STAGES = Q_W;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] rem_u;
    logic [SUM_W-1:0] rem_v;
    logic [Q_W-1:0]   low_u;
    logic [Q_W-1:0]   low_v;
    logic [Q_W-1:0]   q_u;
    logic [Q_W-1:0]   q_v;
    logic             neg_u;
    logic             neg_v;
    logic             zero;
  } cell_word_t;

endpackage
`default_nettype wire

// ===== sv/oct_front.sv =====
// front cell: magnitudes, fold, scaled numerators and first remainders
`default_nettype none
module oct_front (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  input  wire logic                                      adv,
  input  wire logic                                      in_vld,
  input  wire logic signed [oct_pkg::COMPONENT_WIDTH-1:0] normal_x,
  input  wire logic signed [oct_pkg::COMPONENT_WIDTH-1:0] normal_y,
  input  wire logic signed [oct_pkg::COMPONENT_WIDTH-1:0] normal_z,
  output logic                                           out_vld,
  output oct_pkg::cell_word_t                            out_word
);
  import oct_pkg::*;

  logic [COMPONENT_WIDTH-1:0] ax, ay, az, fold;
  logic [MAG_W-1:0]           m_u, m_v;
  logic [NUM_W-1:0]           n_u, n_v;
  cell_word_t                 word_next;

  always_comb begin
    ax = normal_x[COMPONENT_WIDTH-1] ? (COMPONENT_WIDTH'(0) - normal_x) : normal_x;
    ay = normal_y[COMPONENT_WIDTH-1] ? (COMPONENT_WIDTH'(0) - normal_y) : normal_y;
    az = normal_z[COMPONENT_WIDTH-1] ? (COMPONENT_WIDTH'(0) - normal_z) : normal_z;
    fold = normal_z[COMPONENT_WIDTH-1] ? az : '0;
    m_u = MAG_W'(ax) + MAG_W'(fold);
    m_v = MAG_W'(ay) + MAG_W'(fold);
    // m * (2^Q_W - 1)
    n_u = {m_u, {Q_W{1'b0}}} - NUM_W'(m_u);
    n_v = {m_v, {Q_W{1'b0}}} - NUM_W'(m_v);
    word_next.sum   = SUM_W'(ax) + SUM_W'(ay) + SUM_W'(az);
    word_next.rem_u = SUM_W'(n_u[NUM_W-1:Q_W]);
    word_next.rem_v = SUM_W'(n_v[NUM_W-1:Q_W]);
    word_next.low_u = n_u[Q_W-1:0];
    word_next.low_v = n_v[Q_W-1:0];
    word_next.q_u   = '0;
    word_next.q_v   = '0;
    word_next.neg_u = normal_x[COMPONENT_WIDTH-1];
    word_next.neg_v = normal_y[COMPONENT_WIDTH-1];
    word_next.zero  = (word_next.sum == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_word <= word_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/oct_div_cell.sv =====
// one restoring division cell: one quotient bit for both coordinates
`default_nettype none
module oct_div_cell (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          adv,
  input  wire logic          in_vld,
  input  wire oct_pkg::cell_word_t in_word,
  output logic               out_vld,
  output oct_pkg::cell_word_t out_word
);
  import oct_pkg::*;

  logic [SUM_W:0] trial_u, trial_v, diff_u, diff_v;
  logic           take_u, take_v;
  cell_word_t     word_next;

  always_comb begin
    trial_u = {in_word.rem_u, in_word.low_u[Q_W-1]};
    trial_v = {in_word.rem_v, in_word.low_v[Q_W-1]};
    diff_u  = trial_u - {1'b0, in_word.sum};
    diff_v  = trial_v - {1'b0, in_word.sum};
    take_u  = (trial_u >= {1'b0, in_word.sum});
    take_v  = (trial_v >= {1'b0, in_word.sum});
    word_next       = in_word;
    word_next.rem_u = take_u ? diff_u[SUM_W-1:0] : trial_u[SUM_W-1:0];
    word_next.rem_v = take_v ? diff_v[SUM_W-1:0] : trial_v[SUM_W-1:0];
    word_next.low_u = {in_word.low_u[Q_W-2:0], 1'b0};
    word_next.low_v = {in_word.low_v[Q_W-2:0], 1'b0};
    word_next.q_u   = {in_word.q_u[Q_W-2:0], take_u};
    word_next.q_v   = {in_word.q_v[Q_W-2:0], take_v};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_word <= word_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/octahedral_normal_encoder_top.sv =====
// top level of the octahedral normal encoder, front cell and divider chain
`default_nettype none
// Encodes a normal (x, y, z) as two snorm16 octahedral coordinates. One word
// is taken every cycle unless the chain stalls; each result passes one front cell
// for magnitudes and fold, then a chain of 15 division cells, each of which
// settles one quotient bit. The whole chain stalls together when the output
// word is held by oct_ready low; no word is dropped. An all-zero normal gives
// (0, 32767).
module octahedral_normal_encoder_top (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  input  wire logic                                      normal_valid,
  output logic                                           normal_ready,
  input  wire logic signed [oct_pkg::COMPONENT_WIDTH-1:0] normal_x,
  input  wire logic signed [oct_pkg::COMPONENT_WIDTH-1:0] normal_y,
  input  wire logic signed [oct_pkg::COMPONENT_WIDTH-1:0] normal_z,
  output logic                                           oct_valid,
  input  wire logic                                      oct_ready,
  output logic signed [oct_pkg::OUT_W-1:0]               oct_u,
  output logic signed [oct_pkg::OUT_W-1:0]               oct_v
);
  import oct_pkg::*;

  logic       adv;
  logic       vld  [STAGES+1];
  cell_word_t word [STAGES+1];
  cell_word_t last;

  assign adv          = !vld[STAGES] || oct_ready;
  assign normal_ready = adv;

  oct_front u_front (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_vld   (normal_valid),
    .normal_x (normal_x),
    .normal_y (normal_y),
    .normal_z (normal_z),
    .out_vld  (vld[0]),
    .out_word (word[0])
  );

  for (genvar i = 0; i < STAGES; i++) begin : g_cell
    oct_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .in_vld   (vld[i]),
      .in_word  (word[i]),
      .out_vld  (vld[i+1]),
      .out_word (word[i+1])
    );
  end

  assign last      = word[STAGES];
  assign oct_valid = vld[STAGES];

  always_comb begin
    if (last.zero) begin
      oct_u = '0;
      oct_v = {1'b0, {Q_W{1'b1}}};
    end else begin
      oct_u = last.neg_u ? (OUT_W'(0) - {1'b0, last.q_u}) : {1'b0, last.q_u};
      oct_v = last.neg_v ? (OUT_W'(0) - {1'b0, last.q_v}) : {1'b0, last.q_v};
    end
  end

endmodule
`default_nettype wire

// ===== tb/oct_checker.sv =====
// checker that predicts and compares the octahedral code of every accepted normal word
module oct_checker (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      normal_valid,
  input  logic                                      normal_ready,
  input  logic signed [oct_pkg::COMPONENT_WIDTH-1:0] normal_x,
  input  logic signed [oct_pkg::COMPONENT_WIDTH-1:0] normal_y,
  input  logic signed [oct_pkg::COMPONENT_WIDTH-1:0] normal_z,
  input  logic                                      oct_valid,
  input  logic                                      oct_ready,
  input  logic signed [oct_pkg::OUT_W-1:0]           oct_u,
  input  logic signed [oct_pkg::OUT_W-1:0]           oct_v,
  output int                                        fail_count,
  output int                                        pending
);
  import oct_pkg::*;

  localparam longint SNORM_ONE = 32767;

  typedef struct packed {
    logic signed [OUT_W-1:0] u;
    logic signed [OUT_W-1:0] v;
  } oct_code_t;

  oct_code_t pending_codes[$];
  int        errors = 0;

  function automatic logic signed [OUT_W-1:0] snorm_ratio(longint m, longint total, logic neg);
    longint q;
    q = (m * SNORM_ONE) / total;
    if (q > SNORM_ONE) q = SNORM_ONE;
    if (neg) q = -q;
    return q[OUT_W-1:0];
  endfunction

  function automatic oct_code_t predict_code(logic signed [COMPONENT_WIDTH-1:0] x,
                                             logic signed [COMPONENT_WIDTH-1:0] y,
                                             logic signed [COMPONENT_WIDTH-1:0] z);
    longint    sx, sy, sz, ax, ay, az, total;
    oct_code_t code;
    sx = x;
    sy = y;
    sz = z;
    ax = (sx < 0) ? -sx : sx;
    ay = (sy < 0) ? -sy : sy;
    az = (sz < 0) ? -sz : sz;
    total = ax + ay + az;
    if (total == 0) begin
      // zero vector maps to +y
      code.u = '0;
      code.v = SNORM_ONE[OUT_W-1:0];
    end else if (sz < 0) begin
      // lower hemisphere fold, zero counts as positive
      code.u = snorm_ratio(ax + az, total, sx < 0);
      code.v = snorm_ratio(ay + az, total, sy < 0);
    end else begin
      code.u = snorm_ratio(ax, total, sx < 0);
      code.v = snorm_ratio(ay, total, sy < 0);
    end
    return code;
  endfunction

  always @(posedge clk) begin
    oct_code_t want;
    if (!rst) begin
      if (normal_valid && normal_ready)
        pending_codes.insert(pending_codes.size(),
                             predict_code(normal_x, normal_y, normal_z));
      if (oct_valid && oct_ready) begin
        if (pending_codes.size() == 0) begin
          $error("oct word with no normal waiting: oct_u=%0d oct_v=%0d", oct_u, oct_v);
          errors++;
        end else begin
          want = pending_codes.pop_front();
          if (oct_u !== want.u) begin
            $error("oct_u mismatch: expected %0d, actual %0d", want.u, oct_u);
            errors++;
          end
          if (oct_v !== want.v) begin
            $error("oct_v mismatch: expected %0d, actual %0d", want.v, oct_v);
            errors++;
          end
        end
      end
    end
    pending    <= pending_codes.size();
    fail_count <= errors;
  end

endmodule

// ===== tb/tb_top.sv =====
// stimulus, flow control and verdict for the octahedral normal encoder
module tb_top;
  import oct_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_WORDS   = 1130;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              normal_valid = 1'b0;
  logic                              normal_ready;
  logic signed [COMPONENT_WIDTH-1:0] normal_x = '0;
  logic signed [COMPONENT_WIDTH-1:0] normal_y = '0;
  logic signed [COMPONENT_WIDTH-1:0] normal_z = '0;
  logic                              oct_valid;
  logic                              oct_ready = 1'b0;
  logic signed [OUT_W-1:0]           oct_u;
  logic signed [OUT_W-1:0]           oct_v;
  int                                fail_count;
  int                                pending;
  int                                idle_cycles = 0;
  int                                rx_stall = 0;
  logic                              calm = 1'b0;

  octahedral_normal_encoder_top dut (
    .clk          (clk),
    .rst          (rst),
    .normal_valid (normal_valid),
    .normal_ready (normal_ready),
    .normal_x     (normal_x),
    .normal_y     (normal_y),
    .normal_z     (normal_z),
    .oct_valid    (oct_valid),
    .oct_ready    (oct_ready),
    .oct_u        (oct_u),
    .oct_v        (oct_v)
  );

  oct_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .normal_valid (normal_valid),
    .normal_ready (normal_ready),
    .normal_x     (normal_x),
    .normal_y     (normal_y),
    .normal_z     (normal_z),
    .oct_valid    (oct_valid),
    .oct_ready    (oct_ready),
    .oct_u        (oct_u),
    .oct_v        (oct_v),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic signed [COMPONENT_WIDTH-1:0] extreme_component();
    logic signed [COMPONENT_WIDTH-1:0] most_neg;
    most_neg = {1'b1, {(COMPONENT_WIDTH-1){1'b0}}};
    case ($urandom_range(0, 5))
      0: return most_neg;
      1: return COMPONENT_WIDTH'(most_neg + 1);
      2: return '1;
      3: return '0;
      4: return COMPONENT_WIDTH'(1);
      default: return ~most_neg;
    endcase
  endfunction

  // output side back-pressure
  always @(posedge clk) begin
    if (rx_stall > 0) begin
      oct_ready <= 1'b0;
      rx_stall--;
    end else begin
      oct_ready <= 1'b1;
      if (!calm && $urandom_range(0, 5) == 0) rx_stall = pick_gap();
    end
  end

  always @(posedge clk) begin
    if ((normal_valid && normal_ready) || (oct_valid && oct_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_normal(input logic signed [COMPONENT_WIDTH-1:0] x,
                             input logic signed [COMPONENT_WIDTH-1:0] y,
                             input logic signed [COMPONENT_WIDTH-1:0] z);
    int gap;
    gap = (!calm && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      normal_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    normal_valid <= 1'b1;
    normal_x     <= x;
    normal_y     <= y;
    normal_z     <= z;
    do @(posedge clk); while (!normal_ready);
  endtask

  task automatic wait_drained();
    normal_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic random_normal(output logic signed [COMPONENT_WIDTH-1:0] x,
                               output logic signed [COMPONENT_WIDTH-1:0] y,
                               output logic signed [COMPONENT_WIDTH-1:0] z);
    logic [31:0] rx, ry, rz;
    int          kind;
    rx = $urandom();
    ry = $urandom();
    rz = $urandom();
    x = rx[COMPONENT_WIDTH-1:0];
    y = ry[COMPONENT_WIDTH-1:0];
    z = rz[COMPONENT_WIDTH-1:0];
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      // full range as drawn
    end else if (kind < 60) begin
      x = COMPONENT_WIDTH'(int'($urandom_range(0, 8)) - 4);
      y = COMPONENT_WIDTH'(int'($urandom_range(0, 8)) - 4);
      z = COMPONENT_WIDTH'(int'($urandom_range(0, 8)) - 4);
    end else if (kind < 80) begin
      // lower hemisphere
      if (z >= 0) z = ~z;
    end else if (kind < 90) begin
      case ($urandom_range(0, 3))
        0: x = '0;
        1: y = '0;
        2: begin
          x = '0;
          y = '0;
        end
        default: z = '0;
      endcase
    end else begin
      x = extreme_component();
      y = extreme_component();
      z = extreme_component();
    end
  endtask

  initial begin
    logic signed [COMPONENT_WIDTH-1:0] x, y, z;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_normal(0, 0, 0);
    send_normal(32767, 0, 0);
    send_normal(-32768, 0, 0);
    send_normal(0, 32767, 0);
    send_normal(0, -32768, 0);
    send_normal(0, 0, 32767);
    send_normal(0, 0, -32768);
    send_normal(-32768, -32768, -32768);
    send_normal(32767, 32767, 32767);
    send_normal(-32768, 32767, -32768);
    send_normal(0, 5, -3);
    send_normal(7, 0, -2);
    send_normal(0, 0, -1);
    send_normal(1, -1, 0);
    send_normal(-1, 1, 1);
    send_normal(1, 1, -1);
    send_normal(12345, -23456, -9876);
    send_normal(-1, -1, -1);
    send_normal(32767, -32768, 1);
    send_normal(3, 3, 3);
    send_normal(-32767, 0, 32767);
    send_normal(-21846, 21845, -1);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      if (n == RANDOM_WORDS / 2) wait_drained();
      random_normal(x, y, z);
      send_normal(x, y, z);
    end

    wait_drained();
    repeat (24) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== octahedral_normal_encoder_top.f =====
sv/oct_pkg.sv
sv/oct_front.sv
sv/oct_div_cell.sv
sv/octahedral_normal_encoder_top.sv
tb/oct_checker.sv
tb/tb_top.sv
